>>> rtl/projective_warp_bilinear_sampler_unit_defines.svh
// Assertion macros for the projective warp sampler.
`ifndef PROJECTIVE_WARP_BILINEAR_SAMPLER_UNIT_DEFINES_SVH
`define PROJECTIVE_WARP_BILINEAR_SAMPLER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PWBS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define PWBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PWBS_ASSERT(lbl, prop, msg)
`define PWBS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/pwbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pwbs_pkg;
	localparam int TEX_DEPTH = 65536;
	localparam int TEX_AW = $clog2(TEX_DEPTH);
	localparam int MAX_ROW = 4096;
	localparam int SUM_W = 48;
	localparam int DVD_W = SUM_W + 10;
	localparam int QUO_W = DVD_W + 1;
	localparam int CNT_W = $clog2(DVD_W);

	typedef enum logic [2:0] {
		REG_STEP_X, REG_STEP_Y, REG_STEP_W, REG_ORIGIN_X,
		REG_ORIGIN_Y, REG_TEX_WIDTH, REG_TEX_HEIGHT, REG_SMOOTH
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_BEGIN = 2'd1,
		OP_PIXEL = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_COORD, S_CLAMP, S_ADDR, S_RD0, S_RD1, S_RD2,
		S_RD3, S_RD4, S_BLEND_A, S_BLEND_B, S_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic done;
	} div_ctl_t;
endpackage
`default_nettype wire

>>> rtl/pwbs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module pwbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

>>> rtl/pwbs_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Signed (num << 10) / den, restoring, one quotient bit per cycle.
module pwbs_div (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic signed [pwbs_pkg::SUM_W-1:0] num,
	input  wire logic signed [pwbs_pkg::SUM_W-1:0] den,
	output logic                                  done,
	output logic signed [pwbs_pkg::QUO_W-1:0]     quot
);
	localparam int SW = pwbs_pkg::SUM_W;
	localparam int DW = pwbs_pkg::DVD_W;
	localparam int QW = pwbs_pkg::QUO_W;
	localparam int CW = pwbs_pkg::CNT_W;

	logic          run_q, fin_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [SW:0]   rem_q;
	logic [SW-1:0] ad_q;
	logic [DW-1:0] dvd_q, quo_q;
	logic          neg_q, dzero_q, npos_q, nneg_q;
	logic [SW-1:0] an, ad;
	logic [SW:0]   rem_sh;
	logic [SW+1:0] diff;
	logic          ge;

	always_comb begin
		an = num[SW-1] ? SW'(-num) : SW'(num);
		ad = den[SW-1] ? SW'(-den) : SW'(den);
		rem_sh = {rem_q[SW-1:0], dvd_q[DW-1]};
		diff = {1'b0, rem_sh} - {2'b00, ad_q};
		ge = !diff[SW+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= fin_q;
			fin_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			ad_q <= ad;
			dvd_q <= {an, 10'b0};
			neg_q <= num[SW-1] ^ den[SW-1];
			dzero_q <= (den == '0);
			npos_q <= !num[SW-1] && (num != '0);
			nneg_q <= num[SW-1];
		end else if (run_q) begin
			rem_q <= ge ? diff[SW:0] : rem_sh;
			quo_q <= {quo_q[DW-2:0], ge};
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
		end
		if (fin_q) begin
			if (dzero_q) begin
				quot <= npos_q ? (QW'(1) <<< (DW - 1)) :
					nneg_q ? -(QW'(1) <<< (DW - 1)) : '0;
			end else begin
				quot <= neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
			end
		end
	end

	assign done = done_q;
endmodule
`default_nettype wire

>>> rtl/projective_warp_bilinear_sampler_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Dir | Contents
// s_axis    | in  | tuser opcode; tdata address, texel, sums x/y/w, row length
// m_axis    | out | tdata pixel color; tlast last pixel of row
// apb       | in  | eight registers at byte address 8*i, 64-bit data
// Write texel and begin row are taken only in idle.
// A pixel runs the 58-step divide on the two serial dividers in lockstep,
// then reads the one texture port: four texels bilinear, one nearest.
// Reset is asynchronous; texture memory is not cleared.
// A finished pixel waits in the output register; input is taken meanwhile
// unless a second pixel finishes before the first transfer.
`include "projective_warp_bilinear_sampler_unit_defines.svh"
module projective_warp_bilinear_sampler_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// [15:0] texel_address, [47:16] texel_data, [95:48] row_sum_x,
	// [143:96] row_sum_y, [191:144] row_sum_w, [204:192] row_length
	input  wire logic [207:0] s_tdata,
	// [1:0] opcode
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [31:0] pixel_color
	output logic [31:0]       m_tdata,
	output logic              m_tlast,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [5:0]   paddr,
	input  wire logic [63:0]  pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);
	localparam int SW = pwbs_pkg::SUM_W;
	localparam int QW = pwbs_pkg::QUO_W;
	localparam int AW = pwbs_pkg::TEX_AW;

	pwbs_pkg::state_t state_q, state_d;

	// configuration registers
	logic [SW-1:0] step_x_q, step_y_q, step_w_q;
	logic [31:0]   origin_x_q, origin_y_q;
	logic [8:0]    tex_width_q, tex_height_q;
	logic          smooth_q;

	// row state
	logic [SW-1:0] sum_x_q, sum_y_q, sum_w_q;
	logic [12:0]   pixels_left_q;

	// output register
	logic        out_valid_q, out_last_q, last_q;
	logic [31:0] out_color_q, color_q;

	// datapath
	logic signed [QW:0] ux_raw_s1, vy_raw_s1;
	logic [18:0]        u_s2, v_s2;
	logic [AW-1:0]      base_s3;
	logic [7:0]         wx_s3, wy_s3;
	logic [31:0]        t00_q, t01_q, t10_q;
	logic [31:0]        above_q, below_q;

	logic [8:0]  w_eff, h_eff;
	logic [18:0] hi_x, hi_y;
	logic [12:0] len_sat;
	logic        s_acc, cfg_wr, out_free, pix_go;
	pwbs_pkg::opcode_t op;
	pwbs_pkg::div_ctl_t dx_ctl, dy_ctl;
	logic signed [QW-1:0] qx, qy;

	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [31:0]   ram_rdata;
	logic [19:0]   nx, ny;
	logic [9:0]    row_sel, col_sel;
	logic [18:0]   base_full;
	logic [31:0]   above_d, below_d, color_d;

	assign op = pwbs_pkg::opcode_t'(s_tuser);
	assign s_acc = s_tvalid && s_tready;
	assign pix_go = s_acc && (op == pwbs_pkg::OP_PIXEL) && (pixels_left_q != '0);
	assign out_free = !out_valid_q || m_tready;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign w_eff = (tex_width_q < 9'd2) ? 9'd2 : tex_width_q;
	assign h_eff = (tex_height_q < 9'd2) ? 9'd2 : tex_height_q;
	assign hi_x = {w_eff - 9'd1, 10'b0} - 19'd1;
	assign hi_y = {h_eff - 9'd1, 10'b0} - 19'd1;
	assign len_sat = (s_tdata[204:192] > 13'(pwbs_pkg::MAX_ROW)) ?
		13'(pwbs_pkg::MAX_ROW) : s_tdata[204:192];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pwbs_pkg::S_IDLE:    if (pix_go) state_d = pwbs_pkg::S_DIV;
			pwbs_pkg::S_DIV:     if (dx_ctl.done) state_d = pwbs_pkg::S_COORD;
			pwbs_pkg::S_COORD:   state_d = pwbs_pkg::S_CLAMP;
			pwbs_pkg::S_CLAMP:   state_d = pwbs_pkg::S_ADDR;
			pwbs_pkg::S_ADDR:    state_d = pwbs_pkg::S_RD0;
			pwbs_pkg::S_RD0:     state_d = pwbs_pkg::S_RD1;
			pwbs_pkg::S_RD1:     state_d = smooth_q ? pwbs_pkg::S_RD2 : pwbs_pkg::S_DONE;
			pwbs_pkg::S_RD2:     state_d = pwbs_pkg::S_RD3;
			pwbs_pkg::S_RD3:     state_d = pwbs_pkg::S_RD4;
			pwbs_pkg::S_RD4:     state_d = pwbs_pkg::S_BLEND_A;
			pwbs_pkg::S_BLEND_A: state_d = pwbs_pkg::S_BLEND_B;
			pwbs_pkg::S_BLEND_B: state_d = pwbs_pkg::S_DONE;
			pwbs_pkg::S_DONE:    if (out_free) state_d = pwbs_pkg::S_IDLE;
			default:             state_d = pwbs_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer: handshake, divider start, texture port
	always_comb begin
		s_tready = 1'b0;
		ram_we = 1'b0;
		ram_addr = s_tdata[15:0];
		case (state_q)
			pwbs_pkg::S_IDLE: begin
				s_tready = 1'b1;
				ram_we = s_tvalid && (op == pwbs_pkg::OP_WRITE);
			end
			pwbs_pkg::S_RD0: ram_addr = base_s3;
			pwbs_pkg::S_RD1: ram_addr = base_s3 + AW'(1);
			pwbs_pkg::S_RD2: ram_addr = base_s3 + AW'(w_eff);
			pwbs_pkg::S_RD3: ram_addr = base_s3 + AW'(w_eff) + AW'(1);
			default: ram_addr = s_tdata[15:0];
		endcase
	end

	assign dx_ctl.start = pix_go;
	assign dy_ctl.start = pix_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pwbs_pkg::S_IDLE;
			step_x_q <= SW'(16777216);
			step_y_q <= '0;
			step_w_q <= '0;
			origin_x_q <= 32'd512;
			origin_y_q <= 32'd512;
			tex_width_q <= 9'd256;
			tex_height_q <= 9'd256;
			smooth_q <= 1'b1;
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_w_q <= '0;
			pixels_left_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				case (pwbs_pkg::reg_idx_t'(paddr[5:3]))
					pwbs_pkg::REG_STEP_X:     step_x_q <= pwdata[SW-1:0];
					pwbs_pkg::REG_STEP_Y:     step_y_q <= pwdata[SW-1:0];
					pwbs_pkg::REG_STEP_W:     step_w_q <= pwdata[SW-1:0];
					pwbs_pkg::REG_ORIGIN_X:   origin_x_q <= pwdata[31:0];
					pwbs_pkg::REG_ORIGIN_Y:   origin_y_q <= pwdata[31:0];
					pwbs_pkg::REG_TEX_WIDTH:  tex_width_q <= pwdata[8:0];
					pwbs_pkg::REG_TEX_HEIGHT: tex_height_q <= pwdata[8:0];
					pwbs_pkg::REG_SMOOTH:     smooth_q <= pwdata[0];
					default: ;
				endcase
			end
			if (s_acc && op == pwbs_pkg::OP_BEGIN) begin
				sum_x_q <= s_tdata[95:48];
				sum_y_q <= s_tdata[143:96];
				sum_w_q <= s_tdata[191:144];
				pixels_left_q <= len_sat;
			end
			// dividers latch the current sums, so step them right away
			if (pix_go) begin
				sum_x_q <= sum_x_q + step_x_q;
				sum_y_q <= sum_y_q + step_y_q;
				sum_w_q <= sum_w_q + step_w_q;
				pixels_left_q <= pixels_left_q - 13'd1;
			end
			// a new pixel may load in the same cycle the old one transfers
			if (state_q == pwbs_pkg::S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// blend arithmetic, per byte channel
	always_comb begin
		logic [16:0] a, b;
		logic [16:0] m;
		above_d = '0;
		below_d = '0;
		color_d = '0;
		for (int c = 0; c < 4; c++) begin
			a = 17'(t00_q[c*8 +: 8]) * (17'd256 - 17'(wx_s3)) +
				17'(t01_q[c*8 +: 8]) * 17'(wx_s3);
			b = 17'(t10_q[c*8 +: 8]) * (17'd256 - 17'(wx_s3)) +
				17'(ram_rdata[c*8 +: 8]) * 17'(wx_s3);
			above_d[c*8 +: 8] = a[15:8];
			below_d[c*8 +: 8] = b[15:8];
			m = 17'(above_q[c*8 +: 8]) * (17'd256 - 17'(wy_s3)) +
				17'(below_q[c*8 +: 8]) * 17'(wy_s3);
			color_d[c*8 +: 8] = m[15:8];
		end
	end

	// nearest rounds by one half; bilinear floors and keeps the fraction
	always_comb begin
		nx = {1'b0, u_s2} + 20'd512;
		ny = {1'b0, v_s2} + 20'd512;
		row_sel = smooth_q ? {1'b0, v_s2[18:10]} : ny[19:10];
		col_sel = smooth_q ? {1'b0, u_s2[18:10]} : nx[19:10];
		base_full = row_sel * w_eff + 19'(col_sel);
	end

	always_ff @(posedge clk) begin
		if (pix_go) begin
			last_q <= (pixels_left_q == 13'd1);
		end
		if (state_q == pwbs_pkg::S_COORD) begin
			ux_raw_s1 <= (QW + 1)'(qx) - (QW + 1)'($signed(origin_x_q));
			vy_raw_s1 <= (QW + 1)'(qy) - (QW + 1)'($signed(origin_y_q));
		end
		if (state_q == pwbs_pkg::S_CLAMP) begin
			u_s2 <= ux_raw_s1[QW] ? '0 :
				(ux_raw_s1 > $signed({1'b0, QW'(hi_x)})) ? hi_x : ux_raw_s1[18:0];
			v_s2 <= vy_raw_s1[QW] ? '0 :
				(vy_raw_s1 > $signed({1'b0, QW'(hi_y)})) ? hi_y : vy_raw_s1[18:0];
		end
		if (state_q == pwbs_pkg::S_ADDR) begin
			base_s3 <= base_full[AW-1:0];
			wx_s3 <= u_s2[9:2];
			wy_s3 <= v_s2[9:2];
		end
		if (state_q == pwbs_pkg::S_RD1) begin
			t00_q <= ram_rdata;
			color_q <= ram_rdata;
		end
		if (state_q == pwbs_pkg::S_RD2) t01_q <= ram_rdata;
		if (state_q == pwbs_pkg::S_RD3) t10_q <= ram_rdata;
		if (state_q == pwbs_pkg::S_RD4) begin
			above_q <= above_d;
			below_q <= below_d;
		end
		if (state_q == pwbs_pkg::S_BLEND_B) color_q <= color_d;
		if (state_q == pwbs_pkg::S_DONE && out_free) begin
			out_color_q <= color_q;
			out_last_q <= last_q;
		end
	end

	always_comb begin
		prdata = '0;
		case (pwbs_pkg::reg_idx_t'(paddr[5:3]))
			pwbs_pkg::REG_STEP_X:     prdata = 64'(step_x_q);
			pwbs_pkg::REG_STEP_Y:     prdata = 64'(step_y_q);
			pwbs_pkg::REG_STEP_W:     prdata = 64'(step_w_q);
			pwbs_pkg::REG_ORIGIN_X:   prdata = 64'(origin_x_q);
			pwbs_pkg::REG_ORIGIN_Y:   prdata = 64'(origin_y_q);
			pwbs_pkg::REG_TEX_WIDTH:  prdata = 64'(tex_width_q);
			pwbs_pkg::REG_TEX_HEIGHT: prdata = 64'(tex_height_q);
			pwbs_pkg::REG_SMOOTH:     prdata = 64'(smooth_q);
			default:                  prdata = '0;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_color_q;
	assign m_tlast = out_last_q;

	pwbs_ram #(.WIDTH(32), .DEPTH(pwbs_pkg::TEX_DEPTH)) u_tex (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (s_tdata[47:16]),
		.rdata (ram_rdata)
	);

	pwbs_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dx_ctl.start),
		.num    (sum_x_q),
		.den    (sum_w_q),
		.done   (dx_ctl.done),
		.quot   (qx)
	);

	pwbs_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dy_ctl.start),
		.num    (sum_y_q),
		.den    (sum_w_q),
		.done   (dy_ctl.done),
		.quot   (qy)
	);

	`PWBS_ASSERT_NEXT(a_pix_starts_div, pix_go, state_q == pwbs_pkg::S_DIV, "pixel did not start divide")
	`PWBS_ASSERT(a_div_lockstep, dx_ctl.done == dy_ctl.done, "dividers out of step")
	`PWBS_ASSERT(a_we_idle, !ram_we || state_q == pwbs_pkg::S_IDLE, "texture write outside idle")
	`PWBS_ASSERT_NEXT(a_done_loads, state_q == pwbs_pkg::S_DONE && out_free, m_tvalid, "result lost")
endmodule
`default_nettype wire

>>> dv/projective_warp_bilinear_sampler_unit_test.sv
`timescale 1ns / 1ps

// Texture sampler scoreboard: tracks texture contents, row sums and registers,
// and predicts the color and row-end flag of every pixel transfer.
class warp_pixel_scoreboard;
	bit [31:0] texels [pwbs_pkg::TEX_DEPTH];
	bit [47:0] acc_x, acc_y, acc_w;
	int unsigned remaining;
	bit [47:0] inc_x, inc_y, inc_w;
	bit [31:0] org_x, org_y;
	bit [8:0] width, height;
	bit bilinear;
	bit [32:0] expected_pixels [$];

	function new();
		acc_x = '0; acc_y = '0; acc_w = '0; remaining = 0;
		inc_x = 48'd16777216; inc_y = '0; inc_w = '0;
		org_x = 32'd512; org_y = 32'd512; width = 9'd256; height = 9'd256; bilinear = 1'b1;
	endfunction

	function void set_reg(pwbs_pkg::reg_idx_t idx, bit [63:0] v);
		case (idx)
			pwbs_pkg::REG_STEP_X: inc_x = v[47:0];
			pwbs_pkg::REG_STEP_Y: inc_y = v[47:0];
			pwbs_pkg::REG_STEP_W: inc_w = v[47:0];
			pwbs_pkg::REG_ORIGIN_X: org_x = v[31:0];
			pwbs_pkg::REG_ORIGIN_Y: org_y = v[31:0];
			pwbs_pkg::REG_TEX_WIDTH: width = v[8:0];
			pwbs_pkg::REG_TEX_HEIGHT: height = v[8:0];
			default: bilinear = v[0];
		endcase
	endfunction

	// n<<10 / d on magnitudes, truncated; zero divisor saturates to +-2^57, 0 over 0 gives 0
	function longint divide_q10(bit [47:0] nb, bit [47:0] db);
		logic signed [47:0] ns, ds;
		longint n, d;
		bit [63:0] an, ad, q;
		ns = nb; ds = db; n = ns; d = ds;
		an = n < 0 ? -n : n;
		ad = d < 0 ? -d : d;
		if (ad == 0)
			return n > 0 ? (64'sd1 <<< 57) : (n < 0 ? -(64'sd1 <<< 57) : 64'sd0);
		q = (an << 10) / ad;
		return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
	endfunction

	function longint clamp_coord(longint q, bit [31:0] org, int unsigned size);
		logic signed [31:0] os;
		longint u, hi;
		os = org;
		u = q - longint'(os);
		hi = (longint'(size) - 1) * 1024 - 1;
		if (u < 0) u = 0;
		if (u > hi) u = hi;
		return u;
	endfunction

	function bit [31:0] sample_color();
		int unsigned w, h, wx, wy, a, b, m;
		longint u, v, top, bot;
		bit [31:0] t00, t01, t10, t11, color;
		w = width < 2 ? 2 : 32'(width);
		h = height < 2 ? 2 : 32'(height);
		u = clamp_coord(divide_q10(acc_x, acc_w), org_x, w);
		v = clamp_coord(divide_q10(acc_y, acc_w), org_y, h);
		if (!bilinear)
			return texels[16'(((v + 512) >> 10) * w + ((u + 512) >> 10))];
		wx = 32'(int'(u & 1023) >> 2);
		wy = 32'(int'(v & 1023) >> 2);
		top = (v >> 10) * w + (u >> 10);
		bot = top + w;
		t00 = texels[16'(top)]; t01 = texels[16'(top + 1)];
		t10 = texels[16'(bot)]; t11 = texels[16'(bot + 1)];
		color = '0;
		for (int s = 0; s < 32; s += 8) begin
			a = (32'(t00[s+:8]) * (256 - wx) + 32'(t01[s+:8]) * wx) >> 8;
			b = (32'(t10[s+:8]) * (256 - wx) + 32'(t11[s+:8]) * wx) >> 8;
			m = (a * (256 - wy) + b * wy) >> 8;
			color[s+:8] = m[7:0];
		end
		return color;
	endfunction

	function void note_transfer(pwbs_pkg::opcode_t op, bit [207:0] d);
		bit [12:0] len;
		bit [31:0] c;
		case (op)
			pwbs_pkg::OP_WRITE: texels[d[15:0]] = d[47:16];
			pwbs_pkg::OP_BEGIN: begin
				acc_x = d[95:48]; acc_y = d[143:96]; acc_w = d[191:144];
				len = d[204:192];
				remaining = len > pwbs_pkg::MAX_ROW ? pwbs_pkg::MAX_ROW : 32'(len);
			end
			pwbs_pkg::OP_PIXEL: if (remaining != 0) begin
				c = sample_color();
				remaining--;
				expected_pixels.push_back({remaining == 0, c});
				acc_x += inc_x; acc_y += inc_y; acc_w += inc_w;
			end
			default: ;
		endcase
	endfunction

	function bit check_pixel(bit [31:0] color, bit last, output string msg);
		bit [32:0] e;
		if (expected_pixels.size() == 0) begin
			$sformat(msg, "pixel %08h last %0d with none expected", color, last);
			return 0;
		end
		e = expected_pixels.pop_front();
		if (e[31:0] !== color || e[32] !== last) begin
			$sformat(msg, "pixel %08h last %0d, expected %08h last %0d",
				color, last, e[31:0], e[32]);
			return 0;
		end
		return 1;
	endfunction
endclass

module projective_warp_bilinear_sampler_unit_test;
	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready, m_tlast;
	// [15:0] texel_address, [47:16] texel_data, [95:48] row_sum_x,
	// [143:96] row_sum_y, [191:144] row_sum_w, [204:192] row_length
	logic [207:0] s_tdata;
	// [1:0] opcode
	logic [1:0] s_tuser;
	// [31:0] pixel_color
	logic [31:0] m_tdata;
	logic psel, penable, pwrite, pready;
	logic [5:0] paddr;
	logic [63:0] pwdata, prdata;

	warp_pixel_scoreboard sb = new();
	int mismatches = 0;
	int snd_idle_pct = 0, rcv_stall_pct = 0;
	// bumped by the sender to ask the receiver for a long hold-off
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;
	// texture sizes stay at or under this many texels, all written up front
	localparam int FILLED = 512;

	projective_warp_bilinear_sampler_unit i_dut (.*);

	initial clk = 0;
	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

	task automatic report(string msg);
		$display("mismatch: %s", msg);
		mismatches++;
	endtask

	// receiver side: check each transfer, stall at random or for a long hold
	always @(posedge clk) begin
		string msg;
		if (arst_n && m_tvalid && m_tready)
			if (!sb.check_pixel(m_tdata, m_tlast, msg))
				report(msg);
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
		end
	end

	// one transfer; valid stays high afterwards unless the next call idles
	task automatic send(pwbs_pkg::opcode_t op, bit [207:0] d);
		if ($urandom_range(0, 99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_transfer(op, d);
	endtask

	function automatic bit [207:0] pack(bit [15:0] addr, bit [31:0] data,
		bit [47:0] sx, bit [47:0] sy, bit [47:0] sw, bit [12:0] len);
		return {3'b0, len, sw, sy, sx, data, addr};
	endfunction

	function automatic bit [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic bit [47:0] rnd48();
		bit [63:0] r;
		r = rnd64();
		return r[47:0];
	endfunction

	task automatic write_texel(bit [15:0] addr, bit [31:0] data);
		bit [63:0] r;
		r = rnd64();
		send(pwbs_pkg::OP_WRITE, pack(addr, data, r[47:0], rnd48(), rnd48(), r[60:48]));
	endtask

	task automatic begin_row(bit [47:0] sx, bit [47:0] sy, bit [47:0] sw, bit [12:0] len);
		send(pwbs_pkg::OP_BEGIN, pack(16'($urandom), $urandom, sx, sy, sw, len));
	endtask

	task automatic pixel();
		bit [63:0] r;
		r = rnd64();
		send(pwbs_pkg::OP_PIXEL, pack(r[15:0], r[47:16], rnd48(), rnd48(), rnd48(),
			13'($urandom)));
	endtask

	task automatic apb_write(pwbs_pkg::reg_idx_t idx, bit [63:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 6'(idx) << 3;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	// sender pause: nothing outstanding, then let a pixel in flight settle
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_pixels.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic configure(bit [47:0] stx, bit [47:0] sty, bit [47:0] stw,
		bit [31:0] ox, bit [31:0] oy, bit [8:0] w, bit [8:0] h, bit sm);
		wait_drained();
		apb_write(pwbs_pkg::REG_STEP_X, 64'(stx));
		apb_write(pwbs_pkg::REG_STEP_Y, 64'(sty));
		apb_write(pwbs_pkg::REG_STEP_W, 64'(stw));
		apb_write(pwbs_pkg::REG_ORIGIN_X, 64'(ox));
		apb_write(pwbs_pkg::REG_ORIGIN_Y, 64'(oy));
		apb_write(pwbs_pkg::REG_TEX_WIDTH, 64'(w));
		apb_write(pwbs_pkg::REG_TEX_HEIGHT, 64'(h));
		apb_write(pwbs_pkg::REG_SMOOTH, 64'(sm));
	endtask

	function automatic bit [47:0] small_signed(int unsigned mag);
		longint v;
		v = longint'($urandom_range(0, mag));
		return $urandom_range(0, 1) ? 48'(-v) : 48'(v);
	endfunction

	// well-formed row: sums aimed near the texture, or plain noise
	task automatic random_row(output int n);
		bit [47:0] sx, sy, sw;
		longint d, tx, ty;
		int unsigned len;
		n = 0;
		if ($urandom_range(0, 99) < 75) begin
			d = longint'($urandom_range(1 << 22, 1 << 26));
			if ($urandom_range(0, 3) == 0) d = -d;
			tx = longint'($urandom_range(0, (sb.width + 4) * 1024)) - 2048
				+ longint'($signed(sb.org_x));
			ty = longint'($urandom_range(0, (sb.height + 4) * 1024)) - 2048
				+ longint'($signed(sb.org_y));
			sx = 48'((tx * d) >>> 10);
			sy = 48'((ty * d) >>> 10);
			sw = 48'(d);
		end else begin
			sx = rnd48(); sy = rnd48(); sw = rnd48();
			if ($urandom_range(0, 7) == 0) sw = '0;
		end
		len = $urandom_range(0, 9) == 0 ? $urandom_range(8, 40) : $urandom_range(1, 6);
		begin_row(sx, sy, sw, 13'(len));
		n++;
		repeat (len) begin
			pixel();
			n++;
		end
	endtask

	initial begin
		int p, n, cnt;
		bit [8:0] w, h;
		arst_n = 1'b0;
		s_tvalid = 1'b0; s_tuser = pwbs_pkg::OP_WRITE; s_tdata = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the texels any sampled coordinate can reach, plus the top address
		for (int a = 0; a < FILLED; a++) write_texel(16'(a), $urandom);
		write_texel(16'hffff, 32'hffff_ffff);
		write_texel(16'h0000, 32'h0000_0000);
		write_texel(16'h0001, 32'hffff_ffff);

		// directed: wide flat texture, step in x only
		configure(48'd16777216, 48'd0, 48'd0, 32'd512, 32'd512, 9'd256, 9'd2, 1'b1);
		begin_row(48'h7fff_ffff_ffff, 48'h8000_0000_0000, 48'd0, 13'd3); // zero denominator
		pixel(); pixel();
		begin_row(48'd0, 48'd0, 48'd0, 13'd1); // zero over zero
		pixel();
		pixel(); // no pixels left
		send(pwbs_pkg::OP_NONE, pack(16'($urandom), $urandom, rnd48(), rnd48(), rnd48(),
			13'd5));
		begin_row(48'd0, 48'd0, 48'd16777216, 13'd0); // empty row
		pixel();
		begin_row(48'd16777216, 48'd16777216, 48'd16777216, 13'h1fff); // saturates
		begin_row(48'h8000_0000_0000, 48'h7fff_ffff_ffff, 48'h7fff_ffff_ffff, 13'd2);
		pixel(); pixel();
		configure(48'h7fff_ffff_ffff, 48'h8000_0000_0000, 48'h8000_0000_0000,
			32'h8000_0000, 32'h7fff_ffff, 9'd2, 9'd256, 1'b0);
		begin_row(48'd8388608, 48'd8388608, 48'd16777216, 13'd4);
		repeat (4) pixel();
		begin_row(48'hffff_ffff_ffff, 48'd1, 48'hffff_ffff_ffff, 13'd1);
		pixel();

		for (p = 0; p < 12; p++) begin
			case (p % 6)
				0: begin w = 9'd256; h = 9'd2; end
				1: begin w = 9'd2; h = 9'd256; end
				2: begin w = 9'd2; h = 9'd2; end
				3: begin w = 9'd16; h = 9'd32; end
				4: begin w = 9'($urandom_range(2, 22)); h = 9'($urandom_range(2, 22)); end
				default: begin w = 9'd32; h = 9'd16; end
			endcase
			configure(small_signed(1 << 25), small_signed(1 << 25), small_signed(1 << 16),
				32'(small_signed(4096)), 32'(small_signed(4096)), w, h, p[0]);
			case (p % 4)
				0: begin snd_idle_pct = 0; rcv_stall_pct = 0; end
				1: begin snd_idle_pct = 64; rcv_stall_pct = 0; end
				2: begin snd_idle_pct = 0; rcv_stall_pct = 64; end
				default: begin snd_idle_pct = 8; rcv_stall_pct = 8; end
			endcase
			// long receiver hold while the sender keeps pushing pixels
			if (p == 4) hold_reqs++;
			cnt = 0;
			while (cnt < 50) begin
				case ($urandom_range(0, 19))
					0: write_texel(16'($urandom_range(0, FILLED - 1)), $urandom);
					1: write_texel(16'($urandom_range(FILLED, 65535)), $urandom);
					2: pixel();
					3: send(pwbs_pkg::OP_NONE, pack(16'($urandom), $urandom, rnd48(),
						rnd48(), rnd48(), 13'($urandom)));
					default: begin
						random_row(n);
						cnt += n - 1;
					end
				endcase
				cnt++;
			end
			if (p == 0) begin
				snd_idle_pct = 0;
				rcv_stall_pct = 0;
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expected_pixels.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
